// File: sv/grid_bfs_exit_search_defines.svh
// assertion macros shared by the grid search checker
// no dependencies; included by bare file name
`ifndef GRID_BFS_EXIT_SEARCH_DEFINES_SVH
`define GRID_BFS_EXIT_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define GBFS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define GBFS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gbfs_pkg.sv
// types, codes and microprogram of the grid search sequencer
// no dependencies; imported by the sequencer and the top level
`timescale 1ns / 1ps

package gbfs_pkg;

  // stream and configuration widths
  localparam int TDATA_W = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_DW  = 7;
  localparam int CFG_IW  = 2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_START_ROW = 2'd2;
  localparam logic [CFG_IW-1:0] REG_START_COL = 2'd3;

  // register reset values
  localparam logic [6:0] GRID_ROWS_RST = 7'd21;
  localparam logic [6:0] GRID_COLS_RST = 7'd41;
  localparam logic [5:0] START_ROW_RST = 6'd1;
  localparam logic [5:0] START_COL_RST = 6'd1;

  // cell kinds that matter to the walk
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT = 2'd2;

  // neighbor order
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // microcode fields
  localparam int SW = 4;
  localparam int OW = 4;
  localparam int CW_COND = 4;

  // datapath operations
  localparam logic [OW-1:0] OP_NOP   = 4'd0;
  localparam logic [OW-1:0] OP_LOAD  = 4'd1;
  localparam logic [OW-1:0] OP_INIT  = 4'd2;
  localparam logic [OW-1:0] OP_CLEAR = 4'd3;
  localparam logic [OW-1:0] OP_SEED  = 4'd4;
  localparam logic [OW-1:0] OP_POP   = 4'd5;
  localparam logic [OW-1:0] OP_LATCH = 4'd6;
  localparam logic [OW-1:0] OP_RDCUR = 4'd7;
  localparam logic [OW-1:0] OP_NBR   = 4'd8;
  localparam logic [OW-1:0] OP_PUSH  = 4'd9;
  localparam logic [OW-1:0] OP_NEXTK = 4'd10;
  localparam logic [OW-1:0] OP_SET0  = 4'd11;
  localparam logic [OW-1:0] OP_SET1  = 4'd12;
  localparam logic [OW-1:0] OP_EMIT  = 4'd13;

  // jump conditions
  localparam logic [CW_COND-1:0] C_NEVER     = 4'd0;
  localparam logic [CW_COND-1:0] C_ALWAYS    = 4'd1;
  localparam logic [CW_COND-1:0] C_NO_START  = 4'd2;
  localparam logic [CW_COND-1:0] C_START_BAD = 4'd3;
  localparam logic [CW_COND-1:0] C_CLR_MORE  = 4'd4;
  localparam logic [CW_COND-1:0] C_Q_EMPTY   = 4'd5;
  localparam logic [CW_COND-1:0] C_IS_EXIT   = 4'd6;
  localparam logic [CW_COND-1:0] C_NBR_BAD   = 4'd7;
  localparam logic [CW_COND-1:0] C_NBR_SKIP  = 4'd8;
  localparam logic [CW_COND-1:0] C_K_MORE    = 4'd9;
  localparam logic [CW_COND-1:0] C_OUT_BUSY  = 4'd10;

  // program steps
  localparam logic [SW-1:0] S_IDLE     = 4'd0;
  localparam logic [SW-1:0] S_INIT     = 4'd1;
  localparam logic [SW-1:0] S_CLEAR    = 4'd2;
  localparam logic [SW-1:0] S_SEED     = 4'd3;
  localparam logic [SW-1:0] S_POP      = 4'd4;
  localparam logic [SW-1:0] S_LATCH    = 4'd5;
  localparam logic [SW-1:0] S_RDCUR    = 4'd6;
  localparam logic [SW-1:0] S_CHKCUR   = 4'd7;
  localparam logic [SW-1:0] S_NBR      = 4'd8;
  localparam logic [SW-1:0] S_TEST     = 4'd9;
  localparam logic [SW-1:0] S_PUSH     = 4'd10;
  localparam logic [SW-1:0] S_NEXTK    = 4'd11;
  localparam logic [SW-1:0] S_LOOP     = 4'd12;
  localparam logic [SW-1:0] S_NOTFOUND = 4'd13;
  localparam logic [SW-1:0] S_FOUND    = 4'd14;
  localparam logic [SW-1:0] S_EMIT     = 4'd15;

  typedef struct packed {
    logic [OW-1:0]      op;
    logic [CW_COND-1:0] cond;
    logic [SW-1:0]      target;
  } gbfs_uword_t;

  typedef struct packed {
    logic start;
    logic start_bad;
    logic clr_more;
    logic q_empty;
    logic is_exit;
    logic nbr_bad;
    logic nbr_skip;
    logic k_more;
    logic out_busy;
  } gbfs_flags_t;

  // control store; the step after the last wraps back to idle
  function automatic gbfs_uword_t gbfs_rom(input logic [SW-1:0] step);
    gbfs_uword_t w;
    case (step)
      S_IDLE:     w = '{op: OP_LOAD,  cond: C_NO_START,  target: S_IDLE};
      S_INIT:     w = '{op: OP_INIT,  cond: C_START_BAD, target: S_NOTFOUND};
      S_CLEAR:    w = '{op: OP_CLEAR, cond: C_CLR_MORE,  target: S_CLEAR};
      S_SEED:     w = '{op: OP_SEED,  cond: C_NEVER,     target: S_IDLE};
      S_POP:      w = '{op: OP_POP,   cond: C_Q_EMPTY,   target: S_NOTFOUND};
      S_LATCH:    w = '{op: OP_LATCH, cond: C_NEVER,     target: S_IDLE};
      S_RDCUR:    w = '{op: OP_RDCUR, cond: C_NEVER,     target: S_IDLE};
      S_CHKCUR:   w = '{op: OP_NOP,   cond: C_IS_EXIT,   target: S_FOUND};
      S_NBR:      w = '{op: OP_NBR,   cond: C_NBR_BAD,   target: S_NEXTK};
      S_TEST:     w = '{op: OP_NOP,   cond: C_NBR_SKIP,  target: S_NEXTK};
      S_PUSH:     w = '{op: OP_PUSH,  cond: C_NEVER,     target: S_IDLE};
      S_NEXTK:    w = '{op: OP_NEXTK, cond: C_K_MORE,    target: S_NBR};
      S_LOOP:     w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_POP};
      S_NOTFOUND: w = '{op: OP_SET0,  cond: C_ALWAYS,    target: S_EMIT};
      S_FOUND:    w = '{op: OP_SET1,  cond: C_NEVER,     target: S_IDLE};
      S_EMIT:     w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: S_EMIT};
      default:    w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/gbfs_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/gbfs_seq.sv
// step counter and control store of the grid search
// depends on gbfs_pkg (microcode word, flags, rom)
`timescale 1ns / 1ps

module gbfs_seq
  import gbfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  gbfs_flags_t flags,
  output gbfs_uword_t uword
);

  logic [SW-1:0] pc;
  logic [SW-1:0] pc_next;
  logic          take;

  assign uword = gbfs_rom(pc);

  always_comb begin
    case (uword.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !flags.start;
      C_START_BAD: take = flags.start_bad;
      C_CLR_MORE:  take = flags.clr_more;
      C_Q_EMPTY:   take = flags.q_empty;
      C_IS_EXIT:   take = flags.is_exit;
      C_NBR_BAD:   take = flags.nbr_bad;
      C_NBR_SKIP:  take = flags.nbr_skip;
      C_K_MORE:    take = flags.k_more;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b0;
    endcase
    // fall through wraps from the last step to idle
    pc_next = take ? uword.target : pc + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: sv/grid_bfs_exit_search.sv
// grid breadth-first exit search: cells load one per beat; the last beat starts a search
// that sets up, sweeps the visited marks clear over rows*cols cells, then walks the queue
// one dequeued cell per pass of the microcode loop and finishes by emitting the result
// input is held off during the search; the found beat waits in an output register
// rst (sync, high) sends the sequencer to idle, the load address to zero and the
// registers to 21 rows, 41 cols, start (1,1); no memory clearing pass after reset
`timescale 1ns / 1ps

module grid_bfs_exit_search
  import gbfs_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // cell beats
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [1:0] cell_kind, rest zero
  input  logic               s_tlast,   // last_cell
  // result beats
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [0] found, rest zero
  // register writes
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int AW1   = AW + 1;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int PW    = RW + CW;

  // configuration
  logic [6:0] grid_rows;
  logic [6:0] grid_cols;
  logic [5:0] start_row;
  logic [5:0] start_col;

  // sequencer link
  gbfs_uword_t uw;
  gbfs_flags_t flags;

  // datapath registers
  logic [AW-1:0]  load_addr;
  logic [AW1-1:0] head;
  logic [AW1-1:0] tail;
  logic [AW1-1:0] area;
  logic [AW-1:0]  clr;
  logic [RW-1:0]  cur_r;
  logic [CW-1:0]  cur_c;
  logic [RW-1:0]  nr;
  logic [CW-1:0]  nc;
  logic [1:0]     k;
  logic           found_val;
  logic           found_out;

  // combinational datapath
  logic [RNW-1:0]      rows_eff;
  logic [CNW-1:0]      cols_eff;
  logic [RW-1:0]       sr;
  logic [CW-1:0]       sc;
  logic [RW-1:0]       nbr_r;
  logic [CW-1:0]       nbr_c;
  logic                nbr_ok;
  logic [RW-1:0]       ar;
  logic [CW-1:0]       ac;
  logic [RW+CNW-1:0]   prod;
  logic [AW-1:0]       grid_addr;
  logic                in_acc;
  logic                out_busy;

  // memory ports
  logic [KIND_W-1:0] cell_rdata;
  logic              vis_we;
  logic [AW-1:0]     vis_waddr;
  logic              vis_rdata;
  logic              fifo_we;
  logic [AW-1:0]     fifo_waddr;
  logic [PW-1:0]     fifo_rdata;

  assign in_acc   = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;
  assign s_tready = (uw.op == OP_LOAD);
  assign m_tdata  = {{(TDATA_W-1){1'b0}}, found_out};

  // oversized grids clamp to the store size
  assign rows_eff = (32'(grid_rows) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(grid_rows);
  assign cols_eff = (32'(grid_cols) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(grid_cols);
  assign sr = RW'(start_row);
  assign sc = CW'(start_col);

  // neighbor of the current cell in direction k, with bounds check
  always_comb begin
    nbr_r  = cur_r;
    nbr_c  = cur_c;
    nbr_ok = 1'b0;
    case (k)
      DIR_RIGHT: begin
        nbr_c  = cur_c + CW'(1);
        nbr_ok = (CNW'(cur_c) + CNW'(1)) < cols_eff;
      end
      DIR_LEFT: begin
        nbr_c  = cur_c - CW'(1);
        nbr_ok = (cur_c != '0);
      end
      DIR_DOWN: begin
        nbr_r  = cur_r + RW'(1);
        nbr_ok = (RNW'(cur_r) + RNW'(1)) < rows_eff;
      end
      DIR_UP: begin
        nbr_r  = cur_r - RW'(1);
        nbr_ok = (cur_r != '0);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  // one shared row*cols+col address unit for grid reads and visited writes
  always_comb begin
    case (uw.op)
      OP_SEED: begin
        ar = sr;
        ac = sc;
      end
      OP_RDCUR: begin
        ar = cur_r;
        ac = cur_c;
      end
      OP_NBR: begin
        ar = nbr_r;
        ac = nbr_c;
      end
      default: begin
        ar = nr;
        ac = nc;
      end
    endcase
  end

  assign prod      = ar * cols_eff;
  assign grid_addr = AW'(prod) + AW'(ac);

  // status back to the sequencer
  always_comb begin
    flags.start     = in_acc && s_tlast;
    flags.start_bad = (32'(start_row) >= 32'(rows_eff)) || (32'(start_col) >= 32'(cols_eff));
    flags.clr_more  = (AW1'(clr) != (area - AW1'(1)));
    flags.q_empty   = (head == tail);
    flags.is_exit   = (cell_rdata == KIND_EXIT);
    flags.nbr_bad   = !nbr_ok;
    flags.nbr_skip  = !(((cell_rdata == KIND_OPEN) || (cell_rdata == KIND_EXIT)) && !vis_rdata);
    flags.k_more    = (k != DIR_UP);
    flags.out_busy  = out_busy;
  end

  gbfs_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uword (uw)
  );

  // cell kinds, written in load order, read by grid address
  gbfs_ram #(
    .WIDTH (KIND_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (in_acc),
    .waddr (load_addr),
    .wdata (s_tdata[KIND_W-1:0]),
    .raddr (grid_addr),
    .rdata (cell_rdata)
  );

  // visited marks, swept clear over rows*cols before each walk
  assign vis_we    = (uw.op == OP_CLEAR) || (uw.op == OP_SEED) || (uw.op == OP_PUSH);
  assign vis_waddr = (uw.op == OP_CLEAR) ? clr : grid_addr;

  gbfs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (uw.op != OP_CLEAR),
    .raddr (grid_addr),
    .rdata (vis_rdata)
  );

  // work queue of (row, col); each cell enters at most once so it never overflows
  assign fifo_we    = (uw.op == OP_SEED) || (uw.op == OP_PUSH);
  assign fifo_waddr = (uw.op == OP_SEED) ? '0 : tail[AW-1:0];

  gbfs_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata ({ar, ac}),
    .raddr (head[AW-1:0]),
    .rdata (fifo_rdata)
  );

  // control state: registers, load pointer, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_ROWS_RST;
      grid_cols <= GRID_COLS_RST;
      start_row <= START_ROW_RST;
      start_col <= START_COL_RST;
      load_addr <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows <= cfg_data[6:0];
          REG_GRID_COLS: grid_cols <= cfg_data[6:0];
          REG_START_ROW: start_row <= cfg_data[5:0];
          REG_START_COL: start_col <= cfg_data[5:0];
          default: ;
        endcase
      end
      // load pointer wraps at the store size and restarts after each grid
      if (in_acc) begin
        if (s_tlast || (load_addr == AW'(DEPTH - 1))) begin
          load_addr <= '0;
        end else begin
          load_addr <= load_addr + AW'(1);
        end
      end
      if ((uw.op == OP_EMIT) && !out_busy) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // walk registers, all set up by the microprogram before use
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_INIT: begin
        head <= '0;
        tail <= '0;
        clr  <= '0;
        area <= AW1'(rows_eff) * AW1'(cols_eff);
      end
      OP_CLEAR: clr <= clr + AW'(1);
      OP_SEED:  tail <= AW1'(1);
      OP_POP:   head <= head + AW1'(1);
      OP_LATCH: {cur_r, cur_c} <= fifo_rdata;
      OP_RDCUR: k <= DIR_RIGHT;
      OP_NBR: begin
        nr <= nbr_r;
        nc <= nbr_c;
      end
      OP_PUSH:  tail <= tail + AW1'(1);
      OP_NEXTK: k <= k + 2'd1;
      OP_SET0:  found_val <= 1'b0;
      OP_SET1:  found_val <= 1'b1;
      default: ;
    endcase
    if ((uw.op == OP_EMIT) && !out_busy) begin
      found_out <= found_val;
    end
  end

endmodule

// File: sv/gbfs_checker.sv
// port-level checks of the grid search, bound to the top level
// depends on grid_bfs_exit_search_defines.svh
`timescale 1ns / 1ps
`include "grid_bfs_exit_search_defines.svh"

module gbfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled result holds
  `GBFS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

  // only the found bit may be set
  `GBFS_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[7:1] == 7'd0, "result padding not zero")

  // a last beat starts the walk and holds input off
  `GBFS_ASSERT_NEXT(a_hold_off, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during search")

  // input closes only because a last beat was taken
  `GBFS_ASSERT_NOW(a_ready_fall, clk, rst, $fell(s_tready), $past(s_tvalid && s_tlast), "ready fell without last beat")

  // a result only comes out of a search
  `GBFS_ASSERT_NOW(a_result_src, clk, rst, $rose(m_tvalid), $past(!s_tready), "result without search")

endmodule

bind grid_bfs_exit_search gbfs_checker u_gbfs_checker (.*);
